[rtl/mfvs_pkg.sv]
package mfvs_pkg;

  // table geometry
  localparam int MAX_FACES   = 1024;
  localparam int VERTEX_BITS = 32;
  localparam int NODES       = 4;
  localparam int CORNERS     = 8;

  localparam int ADDR_BITS = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_FACES + 1);

  // fixed port field widths
  localparam int SLOT_W  = 10;
  localparam int VID_W   = 32;
  localparam int SIDE_W  = 3;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;

  // input tdata layout, lowest bit first: slot, corner_vertex_0..7, face_side
  localparam int SLOT_LSB   = 0;
  localparam int CORNER_LSB = SLOT_LSB + SLOT_W;
  localparam int SIDE_LSB   = CORNER_LSB + CORNERS * VID_W;
  localparam int IN_USED_W  = SIDE_LSB + SIDE_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_TDATA_W = ((INDEX_W + 7) / 8) * 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_LAST = 3'd5;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef logic [NODES-1:0][VERTEX_BITS-1:0] face_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    face_t                data;
  } ram_wr_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } ram_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // corner number k of a cell side; only valid for sides 0..5
  function automatic logic [2:0] side_corner(input logic [SIDE_W-1:0] side,
                                             input logic [1:0] k);
    logic [2:0] c;
    c = 3'd0;
    unique case (side)
      3'd0:    c = {k, 1'b0};             // x low  {0,2,4,6}
      3'd1:    c = {k, 1'b1};             // x high {1,3,5,7}
      3'd2:    c = {k[1], 1'b0, k[0]};    // y low  {0,1,4,5}
      3'd3:    c = {k[1], 1'b1, k[0]};    // y high {2,3,6,7}
      3'd4:    c = {1'b0, k};             // z low  {0,1,2,3}
      3'd5:    c = {1'b1, k};             // z high {4,5,6,7}
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/mfvs_face_ram.sv]
module mfvs_face_ram (
  input  logic             clk,
  input  mfvs_pkg::ram_wr_t wr,
  input  mfvs_pkg::ram_rd_t rd,
  output mfvs_pkg::face_t   rd_data
);

  mfvs_pkg::face_t mem [mfvs_pkg::MAX_FACES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[rtl/mfvs_match.sv]
module mfvs_match (
  input  mfvs_pkg::face_t entry,
  input  mfvs_pkg::face_t sel,
  output logic            hit
);

  // every selected corner must appear somewhere among the stored nodes
  logic [mfvs_pkg::NODES-1:0] present;

  always_comb begin
    for (int s = 0; s < mfvs_pkg::NODES; s++) begin
      present[s] = 1'b0;
      for (int n = 0; n < mfvs_pkg::NODES; n++) begin
        if (entry[n] == sel[s]) begin
          present[s] = 1'b1;
        end
      end
    end
  end

  assign hit = &present;

endmodule

[rtl/mesh_face_vertex_set_lookup_unit.sv]
// Channel   Dir  Beat contents
// s_*       in   op in tuser; tdata: slot, corner_vertex_0..7, face_side
// m_*       out  found in tuser; tdata: face_index
// cfg_*     in   face_count write
//
// A load is written straight into the table. A query scans the table through the
// single read port of the face RAM, one entry per cycle, stopping at the first
// matching entry or after face_count entries, so at most MAX_FACES entries.
// rst clears control state and face_count; table contents are not cleared.
// A pending result waits in the output register; loads are still taken then,
// a new query waits until the result has moved to the output register.
module mesh_face_vertex_set_lookup_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [9:0] slot, [41:10]..[265:234] corner_vertex_0..7, [268:266] face_side
  input  logic [mfvs_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] op
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [9:0] face_index
  output logic [mfvs_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // [0] found
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [mfvs_pkg::COUNT_W-1:0]        cfg_wdata
);

  mfvs_pkg::state_t state, state_next;

  logic [mfvs_pkg::CNT_BITS-1:0]  count;
  logic [mfvs_pkg::CNT_BITS-1:0]  addr;
  logic [mfvs_pkg::ADDR_BITS-1:0] rd_idx;
  logic                           rd_valid;
  logic                           rd_last;
  mfvs_pkg::face_t                sel;
  logic                           res_found;
  logic [mfvs_pkg::INDEX_W-1:0]   res_index;

  logic                           in_acc;
  logic [mfvs_pkg::SLOT_W-1:0]    in_slot;
  logic [mfvs_pkg::SIDE_W-1:0]    in_side;
  mfvs_pkg::vertex_t              corner [mfvs_pkg::CORNERS];
  mfvs_pkg::face_t                in_face;
  mfvs_pkg::face_t                in_sel;

  mfvs_pkg::ram_wr_t              ram_wr;
  mfvs_pkg::ram_rd_t              ram_rd;
  mfvs_pkg::face_t                rd_data;
  logic                           hit;
  logic                           issue;
  logic                           stop;
  logic                           out_free;

  assign s_tready = (state == mfvs_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_slot  = s_tdata[mfvs_pkg::SLOT_LSB +: mfvs_pkg::SLOT_W];
  assign in_side  = s_tdata[mfvs_pkg::SIDE_LSB +: mfvs_pkg::SIDE_W];
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int j = 0; j < mfvs_pkg::CORNERS; j++) begin
      corner[j] = mfvs_pkg::VERTEX_BITS'(
                    s_tdata[mfvs_pkg::CORNER_LSB + j * mfvs_pkg::VID_W +: mfvs_pkg::VID_W]);
    end
    for (int k = 0; k < mfvs_pkg::NODES; k++) begin
      in_face[k] = corner[k];
      in_sel[k]  = corner[mfvs_pkg::side_corner(in_side, 2'(k))];
    end
  end

  // loads go straight into the table
  always_comb begin
    ram_wr.en   = in_acc && (s_tuser == mfvs_pkg::OP_LOAD)
                  && (32'(in_slot) < 32'(mfvs_pkg::MAX_FACES));
    ram_wr.addr = mfvs_pkg::ADDR_BITS'(in_slot);
    ram_wr.data = in_face;
  end

  // scan: a read is compared in the cycle after it is issued
  assign stop  = rd_valid && (hit || rd_last);
  assign issue = (state == mfvs_pkg::ST_SCAN) && !stop && (addr < count);

  always_comb begin
    ram_rd.en   = issue;
    ram_rd.addr = mfvs_pkg::ADDR_BITS'(addr);
  end

  mfvs_face_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  mfvs_match u_match (
    .entry (rd_data),
    .sel   (sel),
    .hit   (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mfvs_pkg::ST_IDLE: begin
        if (in_acc && (s_tuser == mfvs_pkg::OP_QUERY)) begin
          if ((in_side > mfvs_pkg::SIDE_LAST) || (count == '0)) begin
            state_next = mfvs_pkg::ST_DONE;
          end else begin
            state_next = mfvs_pkg::ST_SCAN;
          end
        end
      end
      mfvs_pkg::ST_SCAN: begin
        if (stop) begin
          state_next = mfvs_pkg::ST_DONE;
        end
      end
      mfvs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mfvs_pkg::ST_IDLE;
        end
      end
      default: state_next = mfvs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_we) begin
      if (32'(cfg_wdata) > 32'(mfvs_pkg::MAX_FACES)) begin
        count <= mfvs_pkg::CNT_BITS'(mfvs_pkg::MAX_FACES);
      end else begin
        count <= mfvs_pkg::CNT_BITS'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr <= '0;
      sel  <= in_sel;
    end else if (issue) begin
      addr <= addr + 1'b1;
    end
    if (issue) begin
      rd_idx  <= mfvs_pkg::ADDR_BITS'(addr);
      rd_last <= ((addr + 1'b1) == count);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mfvs_pkg::ST_IDLE) begin
      res_found <= 1'b0;
      res_index <= '0;
    end else if ((state == mfvs_pkg::ST_SCAN) && stop && hit) begin
      res_found <= 1'b1;
      res_index <= mfvs_pkg::INDEX_W'(rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == mfvs_pkg::ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == mfvs_pkg::ST_DONE) && out_free) begin
      m_tdata <= mfvs_pkg::OUT_TDATA_W'(res_index);
      m_tuser <= res_found;
    end
  end

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == mfvs_pkg::ST_SCAN))
    else $error("table read outstanding outside a scan");

  a_addr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mfvs_pkg::ST_SCAN) |-> (addr <= count))
    else $error("scan pointer ran past face_count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (mfvs_pkg::CNT_BITS'(m_tdata[mfvs_pkg::INDEX_W-1:0]) < count))
    else $error("reported face index beyond face_count");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (s_tuser == mfvs_pkg::OP_QUERY)) |=> !s_tready)
    else $error("query accepted without leaving idle");

endmodule
